FILE: src/epf_pkg.sv
package epf_pkg;

    localparam logic [7:0] ESC_BYTE = 8'hFF;
    localparam logic [7:0] LF_BYTE  = 8'h0A;

    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       final_result;
        logic       checksum_ok;
    } result_t;

    typedef struct packed {
        logic       escape_pending;
        logic [7:0] held_byte;
        logic       held_present;
        logic [7:0] running_sum;
    } pkt_state_t;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == LF_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage

FILE: src/escaped_packet_framer_top.sv
// Channel   Direction  tdata                          tuser      tlast
// s_*       in         [7:0] in_byte                  -          end_of_packet
// m_*       out        [7:0] out_byte, [8] cksum_ok   is_status  final_result
// cfg_*     in         [0] decode_direction           -          -
//
// An input transaction is worked out in the cycle it is accepted; its zero to four
// results go into a four-entry result register and leave one per cycle while
// m_tready is high. Throughput is one input per cycle when each input gives at most
// one result; else an input waits until the last result is taken (encode averages
// up to two per byte). Reset clears the direction (encode) and all packet state; a
// configuration write also clears it. m_tready low holds pending results and s_tready.
module escaped_packet_framer_top
    import epf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] checksum_ok, [15:9] zero
    output logic        m_tuser,   // [0] is_status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // [0] decode_direction
);

    logic             dir_reg;
    pkt_state_t       state_reg;
    pkt_state_t       state_next;
    result_t          q_reg [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg;
    result_t          step_res [MAX_RESULTS];
    logic [CNT_W-1:0] step_cnt;
    logic             accept;
    logic             take;

    epf_step u_step (
        .decode_direction (dir_reg),
        .state_cur        (state_reg),
        .in_byte          (s_tdata),
        .end_of_packet    (s_tlast),
        .state_new        (state_next),
        .results          (step_res),
        .result_count     (step_cnt)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = (cnt_reg != '0);
    assign take      = m_tvalid && m_tready;
    assign s_tready  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_tready);
    assign accept    = s_tvalid && s_tready;

    assign m_tdata = {7'b0, q_reg[0].checksum_ok, q_reg[0].out_byte};
    assign m_tuser = q_reg[0].is_status;
    assign m_tlast = q_reg[0].final_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= DIR_ENCODE;
            state_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dir_reg   <= cfg_data;
                state_reg <= '0;
            end
            else if (accept)
            begin
                state_reg <= state_next;
            end

            if (accept)
            begin
                cnt_reg <= step_cnt;
            end
            else if (take)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg <= step_res;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                q_reg[i] <= q_reg[i + 1];
            end
        end
    end

endmodule

FILE: src/epf_step.sv
module epf_step
    import epf_pkg::*;
(
    input  logic                 decode_direction,
    input  pkt_state_t           state_cur,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_packet,
    output pkt_state_t           state_new,
    output result_t              results [MAX_RESULTS],
    output logic [CNT_W-1:0]     result_count
);

    logic [CNT_W-1:0] idx;
    logic [7:0]       sum;
    logic             emit_held;
    logic             take_byte;
    pkt_state_t       st;

    always_comb
    begin
        idx = '0;
        st  = state_cur;
        sum = '0;
        emit_held = 1'b0;
        take_byte = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            results[i] = '0;
        end

        if (decode_direction == DIR_ENCODE)
        begin
            sum = state_cur.running_sum + in_byte;
            st.running_sum = sum;
            if (needs_escape(in_byte))
            begin
                results[idx[SLOT_W-1:0]].out_byte = ESC_BYTE;
                idx = idx + 1'b1;
            end
            results[idx[SLOT_W-1:0]].out_byte = in_byte;
            idx = idx + 1'b1;
            if (end_of_packet)
            begin
                if (needs_escape(sum))
                begin
                    results[idx[SLOT_W-1:0]].out_byte = ESC_BYTE;
                    idx = idx + 1'b1;
                end
                results[idx[SLOT_W-1:0]].out_byte     = sum;
                results[idx[SLOT_W-1:0]].final_result = 1'b1;
                idx = idx + 1'b1;
                st = '0;
            end
        end
        else
        begin
            // An escaped byte, or any byte that is not an escape, is taken as data.
            take_byte = state_cur.escape_pending || (in_byte != ESC_BYTE);
            emit_held = take_byte && state_cur.held_present;
            if (emit_held)
            begin
                st.running_sum = state_cur.running_sum + state_cur.held_byte;
                results[idx[SLOT_W-1:0]].out_byte = state_cur.held_byte;
                idx = idx + 1'b1;
            end
            if (take_byte)
            begin
                st.escape_pending = 1'b0;
                st.held_byte      = in_byte;
                st.held_present   = 1'b1;
            end
            else
            begin
                st.escape_pending = 1'b1;
            end
            if (end_of_packet)
            begin
                results[idx[SLOT_W-1:0]].out_byte     = st.held_present ? st.held_byte : 8'h00;
                results[idx[SLOT_W-1:0]].is_status    = 1'b1;
                results[idx[SLOT_W-1:0]].final_result = 1'b1;
                results[idx[SLOT_W-1:0]].checksum_ok  = !st.escape_pending && st.held_present
                                                        && (st.held_byte == st.running_sum);
                idx = idx + 1'b1;
                st = '0;
            end
        end

        state_new    = st;
        result_count = idx;
    end

endmodule
